// ===== hw/rtl/bsmh_pkg.sv =====
// Package for the byte stream mixing hash: controller states, the command and
// status words between controller and datapath, and the fixed hash constants.
// No dependencies.
package bsmh_pkg;

	localparam logic [7:0] DigestInit = 8'hAA;
	localparam logic [7:0] SaltInit   = 8'hAB;
	localparam logic       CmdAbsorb  = 1'b0;
	localparam logic       CmdFinish  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABS,
		ST_ABS_END,
		ST_FIN_RD,
		ST_FIN_CMP,
		ST_FIN_OUT
	} state_t;

	typedef struct packed {
		logic start;     // latch the input word and precompute per-word terms
		logic issue;     // read the digest byte at the running index
		logic absorb;    // the issued read belongs to an absorb pass
		logic upd_salt;  // advance salt and position after an absorb pass
		logic out_load;  // load the final-mixed byte into the output register
		logic reinit;    // return salt, position and digest to reset values
	} dp_cmd_t;

	typedef struct packed {
		logic idx_last;  // running index points at the final digest byte
		logic out_fire;  // output word accepted this cycle
		logic out_last;  // the word in the output register is the final one
	} dp_stat_t;

endpackage

// ===== hw/rtl/bsmh_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module bsmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/bsmh_dp.sv =====
// Datapath of the mixing hash: digest RAM with valid bits, salt and position,
// the shared byte lane for absorb and final mixing, and the output register.
// Depends on bsmh_pkg and bsmh_ram.
module bsmh_dp #(
	parameter int DIGEST_BYTES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bsmh_pkg::dp_cmd_t  cmd,
	output bsmh_pkg::dp_stat_t stat,
	input  logic [7:0]         data_byte,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [7:0]         digest_byte,
	output logic [4:0]         byte_index,
	output logic               last
);
	import bsmh_pkg::*;

	localparam int AW = (DIGEST_BYTES > 1) ? $clog2(DIGEST_BYTES) : 1;
	localparam logic [AW-1:0] IdxLast = AW'(DIGEST_BYTES - 1);

	logic [7:0]              salt_q;
	logic [7:0]              pos_q;
	logic [7:0]              byte_q;
	logic [7:0]              post_q;
	logic [7:0]              tbase_q;
	logic [AW-1:0]           idx_q;
	logic [AW-1:0]           rd_idx_s1;
	logic                    rd_ok_s1;
	logic                    wr_s1;
	logic [DIGEST_BYTES-1:0] vld_q;
	logic                    out_valid_q;
	logic [7:0]              out_byte_q;
	logic [4:0]              out_idx_q;
	logic                    out_last_q;

	logic [7:0]  pos_inc;
	logic [15:0] post_prod;
	logic [7:0]  tbase;
	logic [7:0]  ram_rdata;
	logic [7:0]  cur_byte;
	logic [7:0]  j8;
	logic [7:0]  t_abs;
	logic [7:0]  v_abs;
	logic [7:0]  wr_data;
	logic [7:0]  t_fin;
	logic [7:0]  v_fin;
	logic [7:0]  fin_byte;
	logic        out_fire;

	// Per-word terms: salt*(p+1) and b + salt + 31*p, all modulo 256.
	assign pos_inc   = pos_q + 8'd1;
	assign post_prod = salt_q * pos_inc;
	assign tbase     = data_byte + salt_q + {pos_q[2:0], 5'b0} - pos_q;

	// A byte never written since reset or the last finish reads as the init value.
	assign cur_byte = rd_ok_s1 ? ram_rdata : DigestInit;
	assign j8       = 8'(rd_idx_s1);

	assign t_abs   = tbase_q + {j8[3:0], 4'b0} + j8;
	assign v_abs   = cur_byte ^ t_abs;
	assign wr_data = {v_abs[0], v_abs[7:1]} ^ post_q;

	assign t_fin    = salt_q + {j8[2:0], 5'b0} - j8;
	assign v_fin    = cur_byte ^ t_fin;
	assign fin_byte = {v_fin[2:0], v_fin[7:3]} ^ salt_q;

	assign out_fire = out_valid_q & out_ready;

	bsmh_ram #(
		.WIDTH(8),
		.DEPTH(DIGEST_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (wr_s1),
		.waddr(rd_idx_s1),
		.wdata(wr_data),
		.re   (cmd.issue),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_q <= SaltInit;
			pos_q  <= 8'd0;
			idx_q  <= '0;
			wr_s1  <= 1'b0;
			vld_q  <= '0;
		end else begin
			wr_s1 <= cmd.issue & cmd.absorb;
			if (cmd.start) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= (idx_q == IdxLast) ? '0 : idx_q + AW'(1);
			end
			if (cmd.reinit) begin
				salt_q <= SaltInit;
				pos_q  <= 8'd0;
				vld_q  <= '0;
			end else begin
				if (cmd.upd_salt) begin
					salt_q <= {salt_q[2:0], 5'b0} + salt_q + byte_q;
					pos_q  <= pos_inc;
				end
				if (wr_s1) begin
					vld_q[rd_idx_s1] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			byte_q  <= data_byte;
			post_q  <= post_prod[7:0];
			tbase_q <= tbase;
		end
		if (cmd.issue) begin
			rd_idx_s1 <= idx_q;
			rd_ok_s1  <= vld_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_byte_q <= fin_byte;
			out_idx_q  <= 5'(rd_idx_s1);
			out_last_q <= (rd_idx_s1 == IdxLast);
		end
	end

	assign stat.idx_last = (idx_q == IdxLast);
	assign stat.out_fire = out_fire;
	assign stat.out_last = out_last_q;

	assign out_valid   = out_valid_q;
	assign digest_byte = out_byte_q;
	assign byte_index  = out_idx_q;
	assign last        = out_last_q;

endmodule

// ===== hw/rtl/bsmh_ctrl.sv =====
// Controller of the mixing hash: sequences absorb passes over the digest and
// the read, mix and emit loop of a finish. Depends on bsmh_pkg.
module bsmh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               cmd,
	output logic               in_ready,
	input  bsmh_pkg::dp_stat_t stat,
	output bsmh_pkg::dp_cmd_t  dp_cmd
);
	import bsmh_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (cmd == CmdFinish) ? ST_FIN_RD : ST_ABS;
				end
			end
			ST_ABS: begin
				if (stat.idx_last) begin
					state_d = ST_ABS_END;
				end
			end
			ST_ABS_END: begin
				state_d = ST_IDLE;
			end
			ST_FIN_RD: begin
				state_d = ST_FIN_CMP;
			end
			ST_FIN_CMP: begin
				state_d = ST_FIN_OUT;
			end
			ST_FIN_OUT: begin
				if (stat.out_fire) begin
					state_d = stat.out_last ? ST_IDLE : ST_FIN_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready        = (state_q == ST_IDLE);
		dp_cmd          = '0;
		dp_cmd.start    = (state_q == ST_IDLE) & in_valid;
		dp_cmd.issue    = (state_q == ST_ABS) | (state_q == ST_FIN_RD);
		dp_cmd.absorb   = (state_q == ST_ABS);
		dp_cmd.upd_salt = (state_q == ST_ABS_END);
		dp_cmd.out_load = (state_q == ST_FIN_CMP);
		dp_cmd.reinit   = (state_q == ST_FIN_OUT) & stat.out_fire & stat.out_last;
	end

endmodule

// ===== hw/rtl/byte_stream_mixing_hash_256.sv =====
// Top level of the byte stream mixing hash: joins the controller and the
// datapath. Depends on bsmh_pkg, bsmh_ctrl and bsmh_dp.
//
// Input channel (in_valid/in_ready) carries one word: cmd and data_byte.
// cmd = absorb mixes data_byte into every digest byte; cmd = finish applies
// the final mix and emits DIGEST_BYTES words on the output channel
// (out_valid/out_ready) with digest_byte, byte_index and last, then returns
// the hash to its reset state.
// An absorb word walks the digest through the single byte lane, one digest
// byte per cycle, through ST_ABS and then ST_ABS_END, before in_ready returns.
// A finish handles each output word as a RAM read, a mix and a load of the
// output register, and waits while the receiver holds out_ready low; in_ready
// returns the cycle after the last word is taken. One word is worked on at a
// time; in_ready is low while an absorb or finish is in progress.
// A stalled output word stays in the output register, and the read of the
// next digest byte waits until it has been taken.
// After reset, and after each finish, the digest reads as all 0xAA through
// per-byte valid bits, so no clearing pass is needed; the block is ready in
// the first cycle after reset is released.
module byte_stream_mixing_hash_256 #(
	parameter int DIGEST_BYTES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] digest_byte,
	output logic [4:0] byte_index,
	output logic       last
);
	import bsmh_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	bsmh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.cmd     (cmd),
		.in_ready(in_ready),
		.stat    (dp_stat),
		.dp_cmd  (dp_cmd)
	);

	bsmh_dp #(
		.DIGEST_BYTES(DIGEST_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.data_byte  (data_byte),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.digest_byte(digest_byte),
		.byte_index (byte_index),
		.last       (last)
	);

endmodule

// ===== hw/rtl/bsmh_chk.sv =====
// Port-level checker for the mixing hash and the bind that attaches it to the
// top level. Depends on byte_stream_mixing_hash_256.
module bsmh_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] digest_byte,
	input logic [4:0] byte_index,
	input logic       last
);

	// The block never takes a new word while a digest word is on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("in_ready and out_valid high together");

	// A taken input word always keeps the block busy for the next cycle.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after an input word");

	// Taking a non-final digest word keeps the finish going.
	a_more_words: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> !in_ready)
		else $error("block idle before the final digest word");

	// Taking the final digest word returns the block to idle.
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready)
		else $error("block not idle after the final digest word");

	// A stalled digest word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_byte)
			&& $stable(byte_index) && $stable(last))
		else $error("stalled digest word changed");

endmodule

bind byte_stream_mixing_hash_256 bsmh_chk u_bsmh_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.digest_byte(digest_byte),
	.byte_index (byte_index),
	.last       (last)
);
